[design/adress_weight_from_distance_defines.svh]
// Assertion macros for the checker file.
`ifndef ADRESS_WEIGHT_FROM_DISTANCE_DEFINES_SVH
`define ADRESS_WEIGHT_FROM_DISTANCE_DEFINES_SVH

// Checked only while the block is out of reset.
`define AWD_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("adress_weight_from_distance: check failed");

// Checked at every edge, reset included.
`define AWD_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("adress_weight_from_distance: reset check failed");

`endif

[design/awd_pkg.sv]
`timescale 1ns / 1ps
package awd_pkg;
  localparam int unsigned CoordW    = 32;
  localparam int unsigned RadW      = 31;
  localparam int unsigned DistW     = 33;
  localparam int unsigned SqW       = 62;
  localparam int unsigned SumW      = 64;
  localparam int unsigned RootW     = 32;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned PhaseW    = 17;
  localparam int unsigned DivSteps  = 17;
  localparam int unsigned WeightW   = 17;
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrW     = 2;
  localparam int unsigned PolyW     = 33;
  localparam int unsigned Q30W      = 30;
  localparam int unsigned DataW     = 32;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned RegIdxW   = 3;

  localparam logic [PolyW-1:0] SinC1 = 33'd3373259426;
  localparam logic [PolyW-1:0] SinC3 = 33'd5548789346;
  localparam logic [PolyW-1:0] SinC5 = 33'd2738217788;
  localparam logic [PolyW-1:0] SinC7 = 33'd643455389;
  localparam logic [PolyW-1:0] SinC9 = 33'd88203473;
  // Horner coefficients after the leading one, in evaluation order.
  localparam logic [PolyW-1:0] SinHorner [4] = '{SinC7, SinC5, SinC3, SinC1};

  localparam logic [WeightW-1:0] WeightOne  = 17'd65536;
  localparam logic [WeightW-1:0] WeightZero = 17'd0;
  localparam logic [PhaseW-1:0]  PhaseHalf  = 17'd32768;

  typedef enum logic [1:0] {
    REGION_EXPLICIT = 2'd0,
    REGION_HYBRID   = 2'd1,
    REGION_COARSE   = 2'd2
  } awd_region_t;

  typedef enum logic [RegIdxW-1:0] {
    REG_CENTER_X        = 3'd0,
    REG_CENTER_Y        = 3'd1,
    REG_CENTER_Z        = 3'd2,
    REG_RADIUS_EXPLICIT = 3'd3,
    REG_RADIUS_COARSE   = 3'd4
  } awd_reg_t;

  typedef struct packed {
    logic [CoordW-1:0] center_x;
    logic [CoordW-1:0] center_y;
    logic [CoordW-1:0] center_z;
    logic [RadW-1:0]   radius_explicit;
    logic [RadW-1:0]   radius_coarse;
  } awd_cfg_t;

  typedef struct packed {
    awd_region_t     region;
    logic [RadW-1:0] num;
    logic [RadW-1:0] den;
  } awd_job_t;
endpackage

[design/awd_if.sv]
`timescale 1ns / 1ps
interface awd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface awd_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] weight;
  logic [1:0]  region;
  modport source (output valid, weight, region, input ready);
  modport sink (input valid, weight, region, output ready);
endinterface

[design/awd_fifo.sv]
`timescale 1ns / 1ps
module awd_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  awd_pkg::awd_job_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output awd_pkg::awd_job_t head
);
  import awd_pkg::*;

  awd_job_t         mem [QDepth];
  logic [QPtrW-1:0] wptr;
  logic [QPtrW-1:0] rptr;
  logic [QPtrW:0]   count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == (QPtrW+1)'(QDepth));
  assign not_empty = (count != '0);
  assign head      = mem[rptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop) rptr <= rptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= push_data;
  end
endmodule

[design/awd_front.sv]
`timescale 1ns / 1ps
module awd_front (
  input  logic              clk,
  input  logic              rst,
  input  awd_pkg::awd_cfg_t cfg,
  awd_in_if.sink            pos_ch,
  output logic              job_valid,
  output awd_pkg::awd_job_t job,
  input  logic              job_ready
);
  import awd_pkg::*;

  localparam int unsigned RemW = RootW + 3;

  function automatic logic [DistW-1:0] abs_diff(input logic [CoordW-1:0] p,
                                                input logic [CoordW-1:0] c);
    logic signed [DistW-1:0] d;
    d = $signed({p[CoordW-1], p}) - $signed({c[CoordW-1], c});
    return d[DistW-1] ? DistW'(-d) : DistW'(d);
  endfunction

  logic en;

  logic            s1_v;
  logic            s1_sat;
  logic [RadW-1:0] s1_dx;
  logic [RadW-1:0] s1_dy;
  logic [RadW-1:0] s1_dz;
  logic [DistW-1:0] ax;
  logic [DistW-1:0] ay;
  logic [DistW-1:0] az;

  logic           s2_v;
  logic           s2_sat;
  logic [SqW-1:0] s2_qx;
  logic [SqW-1:0] s2_qy;
  logic [SqW-1:0] s2_qz;

  logic             sq_v    [SqrtSteps+1];
  logic             sq_sat  [SqrtSteps+1];
  logic [SumW-1:0]  sq_rad  [SqrtSteps+1];
  logic [RemW-1:0]  sq_rem  [SqrtSteps+1];
  logic [RootW-1:0] sq_root [SqrtSteps+1];

  logic [RemW-1:0]  rem_sh  [SqrtSteps];
  logic [RemW-1:0]  trial   [SqrtSteps];
  logic             take    [SqrtSteps];
  logic [RemW-1:0]  nx_rem  [SqrtSteps];
  logic [RootW-1:0] nx_root [SqrtSteps];

  logic [RootW-1:0] r;
  awd_job_t         job_next;

  assign en           = !job_valid || job_ready;
  assign pos_ch.ready = en;

  assign ax = abs_diff(pos_ch.pos_x, cfg.center_x);
  assign ay = abs_diff(pos_ch.pos_y, cfg.center_y);
  assign az = abs_diff(pos_ch.pos_z, cfg.center_z);

  // One result bit per stage, restoring square root on bit pairs.
  always_comb begin
    for (int k = 0; k < SqrtSteps; k++) begin
      rem_sh[k]  = {sq_rem[k][RemW-3:0], sq_rad[k][SumW-1 -: 2]};
      trial[k]   = RemW'({sq_root[k], 2'b01});
      take[k]    = rem_sh[k] >= trial[k];
      nx_rem[k]  = take[k] ? rem_sh[k] - trial[k] : rem_sh[k];
      nx_root[k] = {sq_root[k][RootW-2:0], take[k]};
    end
  end

  assign r = sq_root[SqrtSteps];

  always_comb begin
    job_next.num    = '0;
    job_next.den    = '0;
    job_next.region = REGION_HYBRID;
    if (sq_sat[SqrtSteps]) begin
      job_next.region = REGION_COARSE;
    end else if (r < RootW'(cfg.radius_explicit)) begin
      job_next.region = REGION_EXPLICIT;
    end else if (r > RootW'(cfg.radius_coarse)) begin
      job_next.region = REGION_COARSE;
    end else begin
      job_next.num = r[RadW-1:0] - cfg.radius_explicit;
      job_next.den = cfg.radius_coarse - cfg.radius_explicit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      job_valid <= 1'b0;
      for (int k = 0; k <= SqrtSteps; k++) sq_v[k] <= 1'b0;
    end else if (en) begin
      s1_v      <= pos_ch.valid;
      s2_v      <= s1_v;
      sq_v[0]   <= s2_v;
      for (int k = 0; k < SqrtSteps; k++) sq_v[k+1] <= sq_v[k];
      job_valid <= sq_v[SqrtSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx  <= ax[RadW-1:0];
      s1_dy  <= ay[RadW-1:0];
      s1_dz  <= az[RadW-1:0];
      s1_sat <= (|ax[DistW-1:RadW]) || (|ay[DistW-1:RadW]) || (|az[DistW-1:RadW]);
      s2_qx  <= SqW'(s1_dx) * SqW'(s1_dx);
      s2_qy  <= SqW'(s1_dy) * SqW'(s1_dy);
      s2_qz  <= SqW'(s1_dz) * SqW'(s1_dz);
      s2_sat <= s1_sat;
      sq_rad[0]  <= SumW'(s2_qx) + SumW'(s2_qy) + SumW'(s2_qz);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_sat[0]  <= s2_sat;
      for (int k = 0; k < SqrtSteps; k++) begin
        sq_rad[k+1]  <= {sq_rad[k][SumW-3:0], 2'b00};
        sq_rem[k+1]  <= nx_rem[k];
        sq_root[k+1] <= nx_root[k];
        sq_sat[k+1]  <= sq_sat[k];
      end
      job <= job_next;
    end
  end
endmodule

[design/awd_back.sv]
`timescale 1ns / 1ps
module awd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  awd_pkg::awd_job_t q_data,
  output logic              q_pop,
  awd_out_if.source         res_ch
);
  import awd_pkg::*;

  localparam int unsigned DivRemW = RadW + 1;
  localparam int unsigned SqPW    = 2 * Q30W;
  localparam int unsigned MulW    = PolyW + Q30W;
  localparam int unsigned HornSt  = 4;

  logic en;

  // Divider stages: quotient bit 16 first.
  logic               d_v    [DivSteps+1];
  logic               d_zero [DivSteps+1];
  awd_region_t        d_reg  [DivSteps+1];
  logic [DivRemW-1:0] d_rem  [DivSteps+1];
  logic [RadW-1:0]    d_den  [DivSteps+1];
  logic [PhaseW-1:0]  d_q    [DivSteps+1];
  logic [DivRemW-1:0] rsh    [DivSteps];
  logic               dtake  [DivSteps];
  logic [DivRemW-1:0] nrem   [DivSteps];

  logic [PhaseW-1:0] x;
  logic              x_hi;
  logic [PhaseW-1:0] a;

  // Polynomial stages.
  logic              e_v;
  awd_region_t       e_reg;
  logic              e_hi;
  logic [Q30W-1:0]   e_a30;
  logic [SqPW-1:0]   e_prod;

  logic              h_v   [HornSt+1];
  awd_region_t       h_reg [HornSt+1];
  logic              h_hi  [HornSt+1];
  logic [Q30W-1:0]   h_a30 [HornSt+1];
  logic [Q30W-1:0]   h_y2  [HornSt+1];
  logic [MulW-1:0]   h_m   [HornSt+1];
  logic [PolyW-1:0]  hp    [HornSt];
  logic [MulW-1:0]   hm    [HornSt];

  logic [PolyW:0]    s_round;
  logic [15:0]       half_sin;
  logic [WeightW-1:0] hyb_w;
  logic [WeightW-1:0] w_next;

  assign en    = !res_ch.valid || res_ch.ready;
  assign q_pop = en && q_valid;

  always_comb begin
    for (int k = 0; k < DivSteps; k++) begin
      rsh[k]   = (k == 0) ? d_rem[k] : {d_rem[k][DivRemW-2:0], 1'b0};
      dtake[k] = rsh[k] >= DivRemW'(d_den[k]);
      nrem[k]  = dtake[k] ? rsh[k] - DivRemW'(d_den[k]) : rsh[k];
    end
  end

  assign x    = d_zero[DivSteps] ? '0 : d_q[DivSteps];
  assign x_hi = x >= PhaseHalf;
  assign a    = x_hi ? x - PhaseHalf : PhaseHalf - x;

  always_comb begin
    for (int k = 0; k < HornSt; k++) begin
      hp[k] = SinHorner[k] - h_m[k][MulW-1:Q30W];
      hm[k] = (k == HornSt - 1) ? MulW'(hp[k]) * MulW'(h_a30[k])
                                : MulW'(hp[k]) * MulW'(h_y2[k]);
    end
  end

  // Round the Q30 sine to Q15 and fold it around one half.
  assign s_round  = (PolyW+1)'(h_m[HornSt][MulW-1:Q30W]) + (PolyW+1)'(1 << 14);
  assign half_sin = (s_round[PolyW:15] > (PolyW-14)'(PhaseHalf)) ? PhaseHalf[15:0]
                                                              : s_round[30:15];
  assign hyb_w    = h_hi[HornSt] ? PhaseHalf - WeightW'(half_sin)
                                 : PhaseHalf + WeightW'(half_sin);

  always_comb begin
    case (h_reg[HornSt])
      REGION_EXPLICIT: w_next = WeightOne;
      REGION_HYBRID:   w_next = hyb_w;
      default:         w_next = WeightZero;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DivSteps; k++) d_v[k] <= 1'b0;
      for (int k = 0; k <= HornSt; k++) h_v[k] <= 1'b0;
      e_v          <= 1'b0;
      res_ch.valid <= 1'b0;
    end else if (en) begin
      d_v[0] <= q_valid;
      for (int k = 0; k < DivSteps; k++) d_v[k+1] <= d_v[k];
      e_v    <= d_v[DivSteps];
      h_v[0] <= e_v;
      for (int k = 0; k < HornSt; k++) h_v[k+1] <= h_v[k];
      res_ch.valid <= h_v[HornSt];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_rem[0]  <= DivRemW'(q_data.num);
      d_den[0]  <= q_data.den;
      d_q[0]    <= '0;
      d_zero[0] <= (q_data.den == '0);
      d_reg[0]  <= q_data.region;
      for (int k = 0; k < DivSteps; k++) begin
        d_rem[k+1]  <= nrem[k];
        d_den[k+1]  <= d_den[k];
        d_q[k+1]    <= {d_q[k][PhaseW-2:0], dtake[k]};
        d_zero[k+1] <= d_zero[k];
        d_reg[k+1]  <= d_reg[k];
      end
      e_reg  <= d_reg[DivSteps];
      e_hi   <= x_hi;
      e_a30  <= {a[15:0], 14'b0};
      e_prod <= SqPW'({a[15:0], 14'b0}) * SqPW'({a[15:0], 14'b0});
      h_reg[0] <= e_reg;
      h_hi[0]  <= e_hi;
      h_a30[0] <= e_a30;
      h_y2[0]  <= e_prod[SqPW-1:Q30W];
      h_m[0]   <= MulW'(SinC9) * MulW'(e_prod[SqPW-1:Q30W]);
      for (int k = 0; k < HornSt; k++) begin
        h_reg[k+1] <= h_reg[k];
        h_hi[k+1]  <= h_hi[k];
        h_a30[k+1] <= h_a30[k];
        h_y2[k+1]  <= h_y2[k];
        h_m[k+1]   <= hm[k];
      end
      res_ch.weight <= w_next;
      res_ch.region <= h_reg[HornSt];
    end
  end
endmodule

[design/adress_weight_from_distance.sv]
`timescale 1ns / 1ps
// AdResS resolution weight of a chunk from its center of mass.
// Input channel pos_ch carries one word per chunk: pos_x, pos_y, pos_z in signed
// Q16.16. Output channel res_ch returns one word per input word, in order:
// weight in unsigned Q1.16 (65536 is one) and a region code (explicit, hybrid,
// coarse). Both channels use valid/ready; a word moves when both are high.
// The user must write the box center and the two radii over the APB port only
// while the block is idle; the block itself does not enforce this. A read
// returns the stored value. From input acceptance to output valid, a word
// passes the front (distance, squares, a 32-stage square root pipeline and
// classification), the job queue, and the back (a 17-stage divider for the
// hybrid phase, six polynomial stages for the cosine profile and the output
// register). Throughput is one word per clock cycle while the receiver does
// not stall, set by the fully pipelined root, divider and polynomial units.
// Reset clears the configuration registers to zero and drops every word in
// flight. When the receiver stalls, the back pipeline holds; the front keeps
// accepting until the four-entry job queue between the two fills up.
module adress_weight_from_distance (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [awd_pkg::AddrW-1:0] paddr,
  input  logic [awd_pkg::DataW-1:0] pwdata,
  output logic [awd_pkg::DataW-1:0] prdata,
  output logic                      pready,
  awd_in_if.sink                    pos_ch,
  awd_out_if.source                 res_ch
);
  import awd_pkg::*;

  awd_cfg_t cfg;
  logic     wr_en;
  awd_reg_t reg_idx;

  logic     job_valid;
  awd_job_t job;
  logic     q_full;
  logic     q_pop;
  logic     q_valid;
  awd_job_t q_head;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = awd_reg_t'(paddr[AddrW-1:2]);

  // Configuration registers, one 32-bit slot each.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CENTER_X:        cfg.center_x <= pwdata;
        REG_CENTER_Y:        cfg.center_y <= pwdata;
        REG_CENTER_Z:        cfg.center_z <= pwdata;
        REG_RADIUS_EXPLICIT: cfg.radius_explicit <= pwdata[RadW-1:0];
        REG_RADIUS_COARSE:   cfg.radius_coarse <= pwdata[RadW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CENTER_X:        prdata = cfg.center_x;
      REG_CENTER_Y:        prdata = cfg.center_y;
      REG_CENTER_Z:        prdata = cfg.center_z;
      REG_RADIUS_EXPLICIT: prdata = DataW'(cfg.radius_explicit);
      REG_RADIUS_COARSE:   prdata = DataW'(cfg.radius_coarse);
      default:             prdata = '0;
    endcase
  end

  // The front classifies each chunk and hands every job, with the phase
  // numerator and denominator for hybrid ones, to the back through a short queue.
  awd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pos_ch    (pos_ch),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (!q_full)
  );

  awd_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_valid),
    .push_data (job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  awd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_head),
    .q_pop   (q_pop),
    .res_ch  (res_ch)
  );
endmodule

[design/awd_checker.sv]
`timescale 1ns / 1ps
`include "adress_weight_from_distance_defines.svh"
module awd_props (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [16:0] res_weight,
  input logic [1:0]  res_region,
  input logic        pready
);
  import awd_pkg::*;

  `AWD_ASSERT_ALWAYS(a_no_word_after_reset, rst |=> !res_valid)
  `AWD_ASSERT(a_hold_when_stalled, res_valid && !res_ready |=> res_valid)
  `AWD_ASSERT(a_explicit_full, res_valid && res_region == REGION_EXPLICIT |-> res_weight == WeightOne)
  `AWD_ASSERT(a_coarse_zero, res_valid && res_region == REGION_COARSE |-> res_weight == WeightZero)
  `AWD_ASSERT_ALWAYS(a_pready_high, pready)
endmodule

bind adress_weight_from_distance awd_props u_awd_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res_ch.valid),
  .res_ready  (res_ch.ready),
  .res_weight (res_ch.weight),
  .res_region (res_ch.region),
  .pready     (pready)
);
